// ===== design/fdtc_pkg.sv =====
// fdtc_pkg: shared widths, frame marks, reset values and tree thresholds
// for the framed decimal tree classifier; no dependencies
package fdtc_pkg;

    localparam int BYTE_W    = 8;
    localparam int VAL_W     = 16;
    localparam int COUNT_W   = 7;
    localparam int CODE_W    = 2;
    localparam int NUM_FEATS = 5;

    // default longest frame, 's' included
    localparam int MAX_FRAME_LEN_DEF = 64;

    // frame marks
    localparam logic [BYTE_W-1:0] START_MARK = 8'h73;  // 's'
    localparam logic [BYTE_W-1:0] END_MARK   = 8'h23;  // '#'
    localparam logic [BYTE_W-1:0] NULL_BYTE  = 8'h00;

    // cleared values: a missing digit counts as 0 - 48 times its weight
    localparam logic [VAL_W-1:0] DEPTH_MISSING = 16'd65488;
    localparam logic [VAL_W-1:0] FEAT_MISSING  = 16'd60208;

    // frame position of the depth digit and of the first feature digit
    localparam logic [COUNT_W-1:0] DEPTH_POS     = 7'd1;
    localparam int                 FEAT_POS_BASE = 3;
    localparam int                 FEAT_STRIDE   = 4;

    // feature slots
    localparam int FEAT_CRU = 1;
    localparam int FEAT_AMP = 2;
    localparam int FEAT_SYM = 3;
    localparam int FEAT_DEV = 4;

    // supported tree depths
    localparam logic [VAL_W-1:0] DEPTH_2 = 16'd2;
    localparam logic [VAL_W-1:0] DEPTH_3 = 16'd3;
    localparam logic [VAL_W-1:0] DEPTH_4 = 16'd4;

    // split thresholds
    localparam logic [VAL_W-1:0] THR_AMP_LO   = 16'd37;
    localparam logic [VAL_W-1:0] THR_AMP_MIN  = 16'd4;
    localparam logic [VAL_W-1:0] THR_AMP_MID  = 16'd42;
    localparam logic [VAL_W-1:0] THR_AMP_HI   = 16'd60;
    localparam logic [VAL_W-1:0] THR_SYM_LO   = 16'd50;
    localparam logic [VAL_W-1:0] THR_SYM_HI   = 16'd84;
    localparam logic [VAL_W-1:0] THR_CRU      = 16'd45;
    localparam logic [VAL_W-1:0] THR_DEV_MIN  = 16'd1;
    localparam logic [VAL_W-1:0] THR_DEV_HI   = 16'd8;

    // class codes
    typedef enum logic [CODE_W-1:0] {
        CLASS_0   = 2'd0,
        CLASS_1   = 2'd1,
        CLASS_2   = 2'd2,
        CLASS_ERR = 2'd3
    } class_code_t;

    typedef logic [NUM_FEATS-1:0][VAL_W-1:0] feat_arr_t;

    // frame values handed to the tree
    typedef struct packed {
        logic [VAL_W-1:0] depth;
        feat_arr_t        feats;
    } frame_vals_t;

endpackage

// ===== design/fdtc_rx_if.sv =====
// fdtc_rx_if: valid/ready channel carrying one received byte
// depends on fdtc_pkg for the byte width
interface fdtc_rx_if;
    logic                        valid;
    logic                        ready;
    logic [fdtc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/fdtc_class_if.sv =====
// fdtc_class_if: valid/ready channel carrying one class code
// depends on fdtc_pkg for the code width
interface fdtc_class_if;
    logic                        valid;
    logic                        ready;
    logic [fdtc_pkg::CODE_W-1:0] class_code;

    modport source (output valid, output class_code, input ready);
    modport sink   (input valid, input class_code, output ready);
endinterface

// ===== design/fdtc_tree.sv =====
// fdtc_tree: fixed decision trees for depth 2, 3 and 4 over the frame values
// depends on fdtc_pkg
module fdtc_tree (
    input  fdtc_pkg::frame_vals_t vals,
    output fdtc_pkg::class_code_t code
);
    import fdtc_pkg::*;

    logic [VAL_W-1:0] cru;
    logic [VAL_W-1:0] amp;
    logic [VAL_W-1:0] sym;
    logic [VAL_W-1:0] dev;
    class_code_t      code_d2;
    class_code_t      code_d3;
    class_code_t      code_d4;

    assign cru = vals.feats[FEAT_CRU];
    assign amp = vals.feats[FEAT_AMP];
    assign sym = vals.feats[FEAT_SYM];
    assign dev = vals.feats[FEAT_DEV];

    // depth 2 tree
    always_comb
    begin
        priority if (amp <= THR_AMP_LO)
            code_d2 = CLASS_1;
        else if (sym <= THR_SYM_LO)
            code_d2 = CLASS_0;
        else
            code_d2 = CLASS_2;
    end

    // depth 3 tree
    always_comb
    begin
        priority if (amp <= THR_AMP_LO)
            code_d3 = CLASS_1;
        else if (sym <= THR_SYM_LO)
            code_d3 = (cru <= THR_CRU) ? CLASS_0 : CLASS_2;
        else if (sym <= THR_SYM_HI)
            code_d3 = CLASS_2;
        else
            code_d3 = CLASS_0;
    end

    // depth 4 tree
    always_comb
    begin
        priority if (amp <= THR_AMP_LO)
        begin
            if (amp <= THR_AMP_MIN)
                code_d4 = (dev <= THR_DEV_MIN) ? CLASS_1 : CLASS_0;
            else
                code_d4 = CLASS_1;
        end
        else if (sym <= THR_SYM_LO)
        begin
            if (cru <= THR_CRU)
                code_d4 = (amp <= THR_AMP_MID) ? CLASS_1 : CLASS_0;
            else
                code_d4 = (dev <= THR_DEV_HI) ? CLASS_2 : CLASS_0;
        end
        else if (sym <= THR_SYM_HI)
            code_d4 = CLASS_2;
        else
            code_d4 = (amp <= THR_AMP_HI) ? CLASS_1 : CLASS_0;
    end

    // pick the tree by depth, anything else is an error
    always_comb
    begin
        priority if (vals.depth == DEPTH_2)
            code = code_d2;
        else if (vals.depth == DEPTH_3)
            code = code_d3;
        else if (vals.depth == DEPTH_4)
            code = code_d4;
        else
            code = CLASS_ERR;
    end

endmodule

// ===== design/framed_decimal_tree_classifier_top.sv =====
// framed_decimal_tree_classifier_top: frame parser, decimal accumulators and
// output register; depends on fdtc_pkg, fdtc_rx_if, fdtc_class_if, fdtc_tree
//
//   port   dir  fields       transfer when
//   rx     in   rx_byte      rx.valid && rx.ready
//   res    out  class_code   res.valid && res.ready
//
// One byte per cycle while the output register can take a result: a byte is
// first held in the input register, then the frame state updates and a class
// code on '#' lands in the output register. Result valid is registered with it,
// when the '#' leaves the input register.
// Reset clears the frame state and both valid flags.
// A result held in the output register stalls the input register only while
// res.ready is low; rx.ready then drops once the input register is full.
module framed_decimal_tree_classifier_top #(
    parameter int MAX_FRAME_LEN = fdtc_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    fdtc_rx_if.sink             rx,
    fdtc_class_if.source        res
);
    import fdtc_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_LEN);

    // input register
    logic                 in_valid_reg;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 advance;

    // frame state
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [VAL_W-1:0]     depth_reg;
    logic [VAL_W-1:0]     depth_next;
    feat_arr_t            feats_reg;
    feat_arr_t            feats_next;

    // output register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    class_code_t          out_code_reg;
    logic                 emit;

    frame_vals_t          vals;
    class_code_t          tree_code;

    logic [VAL_W-1:0]     b1;
    logic [VAL_W-1:0]     b10;
    logic [VAL_W-1:0]     b100;

    // the input register moves on whenever the output register can take a result
    assign advance  = !out_valid_reg || res.ready;
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (rx.ready)
            in_valid_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            in_byte_reg <= rx.rx_byte;
    end

    // weighted byte values by shift and add
    assign b1   = VAL_W'(in_byte_reg);
    assign b10  = (b1 << 3) + (b1 << 1);
    assign b100 = (b1 << 6) + (b1 << 5) + (b1 << 2);

    // decision tree over the current frame values
    assign vals.depth = depth_reg;
    assign vals.feats = feats_reg;

    fdtc_tree u_tree (
        .vals (vals),
        .code (tree_code)
    );

    // frame parsing and accumulation
    always_comb
    begin
        count_next = count_reg;
        depth_next = depth_reg;
        feats_next = feats_reg;
        emit       = 1'b0;
        if (in_valid_reg && advance && in_byte_reg != NULL_BYTE)
        begin
            priority if (count_reg == '0)
            begin
                if (in_byte_reg == START_MARK)
                    count_next = COUNT_W'(1);
            end
            else if (count_reg >= MAX_COUNT)
            begin
                count_next = '0;
                depth_next = DEPTH_MISSING;
                feats_next = {NUM_FEATS{FEAT_MISSING}};
            end
            else if (in_byte_reg == END_MARK)
            begin
                emit       = 1'b1;
                count_next = '0;
                depth_next = DEPTH_MISSING;
                feats_next = {NUM_FEATS{FEAT_MISSING}};
            end
            else
            begin
                count_next = count_reg + COUNT_W'(1);
                if (count_reg == DEPTH_POS)
                    depth_next = depth_reg + b1;
                for (int f = 0; f < NUM_FEATS; f++)
                begin
                    if (count_reg == COUNT_W'(FEAT_POS_BASE + FEAT_STRIDE * f))
                        feats_next[f] = feats_reg[f] + b100;
                    else if (count_reg == COUNT_W'(FEAT_POS_BASE + FEAT_STRIDE * f + 1))
                        feats_next[f] = feats_reg[f] + b10;
                    else if (count_reg == COUNT_W'(FEAT_POS_BASE + FEAT_STRIDE * f + 2))
                        feats_next[f] = feats_reg[f] + b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            depth_reg <= DEPTH_MISSING;
            feats_reg <= {NUM_FEATS{FEAT_MISSING}};
        end
        else
        begin
            count_reg <= count_next;
            depth_reg <= depth_next;
            feats_reg <= feats_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            out_code_reg <= tree_code;
    end

    assign res.valid      = out_valid_reg;
    assign res.class_code = out_code_reg;

endmodule

// ===== verif/framed_decimal_tree_classifier_top_tb.sv =====
`timescale 1ns / 1ps
// framed_decimal_tree_classifier_top_tb: self-checking bench for the framed decimal tree
// classifier; a byte-level predictor feeds a queue of class codes checked on every transfer
// depends on fdtc_pkg, fdtc_rx_if, fdtc_class_if and framed_decimal_tree_classifier_top
module framed_decimal_tree_classifier_top_tb;
    import fdtc_pkg::*;

    localparam int MAX_LEN    = MAX_FRAME_LEN_DEF;
    localparam int MAX_GAP    = 8;
    localparam int RAND_BYTES = 450;
    localparam int RAND_CODES = 12;
    localparam int DRAIN_CYC  = 8;

    localparam logic [BYTE_W-1:0] DIGIT_0   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] SEP_CH    = 8'h2c;  // ','
    localparam logic [BYTE_W-1:0] FILL_BASE = 8'h41;  // 'A'

    logic clk;
    logic rst_n;

    fdtc_rx_if    rx_ch ();
    fdtc_class_if res_ch ();

    framed_decimal_tree_classifier_top #(
        .MAX_FRAME_LEN(MAX_LEN)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    // predicted frame state
    logic [COUNT_W-1:0] frame_len;
    logic [VAL_W-1:0]   depth_acc;
    logic [VAL_W-1:0]   feat_acc [NUM_FEATS];

    class_code_t        pending_codes [$];
    logic [BYTE_W-1:0]  frame_q [$];
    int                 err_cnt;
    int                 frame_bytes;
    int                 codes_predicted;
    bit                 rx_burst;
    bit                 res_burst;

    // clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // back to the no-frame state
    function automatic void clear_frame_model();
        frame_len = '0;
        depth_acc = DEPTH_MISSING;
        for (int s = 0; s < NUM_FEATS; s++)
            feat_acc[s] = FEAT_MISSING;
    endfunction

    // class chosen by the tree for the current depth
    function automatic class_code_t tree_class();
        logic [VAL_W-1:0] cru;
        logic [VAL_W-1:0] amp;
        logic [VAL_W-1:0] sym;
        logic [VAL_W-1:0] dev;
        cru = feat_acc[FEAT_CRU];
        amp = feat_acc[FEAT_AMP];
        sym = feat_acc[FEAT_SYM];
        dev = feat_acc[FEAT_DEV];
        if (depth_acc == DEPTH_2)
        begin
            if (amp <= THR_AMP_LO)
                return CLASS_1;
            return (sym <= THR_SYM_LO) ? CLASS_0 : CLASS_2;
        end
        if (depth_acc == DEPTH_3)
        begin
            if (amp <= THR_AMP_LO)
                return CLASS_1;
            if (sym <= THR_SYM_LO)
                return (cru <= THR_CRU) ? CLASS_0 : CLASS_2;
            return (sym <= THR_SYM_HI) ? CLASS_2 : CLASS_0;
        end
        if (depth_acc == DEPTH_4)
        begin
            if (amp <= THR_AMP_LO)
            begin
                if (amp <= THR_AMP_MIN)
                    return (dev <= THR_DEV_MIN) ? CLASS_1 : CLASS_0;
                return CLASS_1;
            end
            if (sym <= THR_SYM_LO)
            begin
                if (cru <= THR_CRU)
                    return (amp <= THR_AMP_MID) ? CLASS_1 : CLASS_0;
                return (dev <= THR_DEV_HI) ? CLASS_2 : CLASS_0;
            end
            if (sym <= THR_SYM_HI)
                return CLASS_2;
            return (amp <= THR_AMP_HI) ? CLASS_1 : CLASS_0;
        end
        return CLASS_ERR;
    endfunction

    // fold one transferred byte into the frame state
    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        int              rel;
        int              slot;
        int              w;
        if (b == NULL_BYTE)
            return;
        if (frame_len == '0)
        begin
            if (b == START_MARK)
                frame_len = 7'd1;
            return;
        end
        // frame already full: the byte kills it
        if (int'(frame_len) >= MAX_LEN)
        begin
            clear_frame_model();
            return;
        end
        if (b == END_MARK)
        begin
            pending_codes.push_back(tree_class());
            codes_predicted++;
            clear_frame_model();
            return;
        end
        if (frame_len == DEPTH_POS)
            depth_acc = depth_acc + VAL_W'(b);
        else if (int'(frame_len) >= FEAT_POS_BASE)
        begin
            rel  = int'(frame_len) - FEAT_POS_BASE;
            slot = rel / FEAT_STRIDE;
            case (rel % FEAT_STRIDE)
                0:       w = 100;
                1:       w = 10;
                2:       w = 1;
                default: w = 0;  // separator
            endcase
            if (slot < NUM_FEATS && w != 0)
                feat_acc[slot] = feat_acc[slot] + VAL_W'(int'(b) * w);
        end
        frame_len = frame_len + 7'd1;
    endfunction

    // s, depth, then five comma-led three-digit features, then '#'
    function automatic void build_frame(input logic [BYTE_W-1:0] depth_ch,
                                        input int dur, cru, amp, sym, dev);
        int vals [NUM_FEATS];
        vals[0] = dur;
        vals[1] = cru;
        vals[2] = amp;
        vals[3] = sym;
        vals[4] = dev;
        frame_q = {};
        frame_q.push_back(START_MARK);
        frame_q.push_back(depth_ch);
        for (int s = 0; s < NUM_FEATS; s++)
        begin
            frame_q.push_back(SEP_CH);
            frame_q.push_back(BYTE_W'(DIGIT_0 + vals[s] / 100));
            frame_q.push_back(BYTE_W'(DIGIT_0 + (vals[s] / 10) % 10));
            frame_q.push_back(BYTE_W'(DIGIT_0 + vals[s] % 10));
        end
        frame_q.push_back(END_MARK);
    endfunction

    // one byte transfer on the rx channel, then predict
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
        repeat (gap)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        absorb_byte(b);
    endtask

    task automatic send_frame_q();
        frame_bytes += frame_q.size();
        foreach (frame_q[i])
            send_byte(frame_q[i]);
    endtask

    task automatic send_tree_frame(input logic [BYTE_W-1:0] depth_ch,
                                   input int dur, cru, amp, sym, dev);
        build_frame(depth_ch, dur, cru, amp, sym, dev);
        send_frame_q();
    endtask

    // 's', body_len letters, then the closing byte
    task automatic send_long_frame(input int body_len, input logic [BYTE_W-1:0] closer);
        frame_q = {};
        frame_q.push_back(START_MARK);
        for (int i = 0; i < body_len; i++)
            frame_q.push_back(BYTE_W'(FILL_BASE + i % 26));
        frame_q.push_back(closer);
        send_frame_q();
    endtask

    // bytes with no frame open are dropped
    task automatic test_idle_drops();
        send_byte(NULL_BYTE);
        send_byte(8'hff);
        send_byte("a");
        send_byte(END_MARK);
        send_byte(8'h80);
        send_byte(8'h01);
    endtask

    // every leaf of the three trees, thresholds on both sides
    task automatic test_tree_paths();
        send_tree_frame("2", 0, 0, 37, 0, 0);
        send_tree_frame("2", 999, 0, 38, 50, 0);
        send_tree_frame("2", 0, 999, 38, 51, 999);
        send_tree_frame("3", 0, 0, 0, 0, 0);
        send_tree_frame("3", 0, 45, 500, 50, 0);
        send_tree_frame("3", 0, 46, 500, 50, 0);
        send_tree_frame("3", 0, 0, 500, 84, 0);
        send_tree_frame("3", 0, 0, 500, 85, 0);
        send_tree_frame("4", 0, 0, 4, 0, 1);
        send_tree_frame("4", 0, 0, 4, 0, 2);
        send_tree_frame("4", 0, 0, 5, 0, 0);
        send_tree_frame("4", 0, 45, 42, 50, 0);
        send_tree_frame("4", 0, 45, 43, 50, 0);
        send_tree_frame("4", 0, 46, 43, 50, 8);
        send_tree_frame("4", 0, 46, 43, 50, 9);
        send_tree_frame("4", 0, 0, 60, 84, 0);
        send_tree_frame("4", 0, 0, 60, 85, 0);
        send_tree_frame("4", 0, 0, 61, 85, 0);
    endtask

    // odd depths, missing fields, null and non-digit bytes, early end
    task automatic test_special_frames();
        // no depth digit at all
        frame_q = {START_MARK, END_MARK};
        send_frame_q();
        send_tree_frame("5", 0, 0, 0, 0, 0);
        send_tree_frame("1", 0, 0, 500, 0, 0);
        send_tree_frame("x", 0, 0, 500, 0, 0);
        // null bytes inside a frame are skipped
        build_frame("2", 0, 0, 500, 0, 0);
        frame_q.insert(1, NULL_BYTE);
        frame_q.insert(frame_q.size() - 1, NULL_BYTE);
        send_frame_q();
        // non-digit bytes at value positions
        build_frame("4", 123, 456, 789, 12, 3);
        frame_q[4]  = 8'hff;
        frame_q[12] = "z";
        frame_q[20] = 8'h80;
        send_frame_q();
        // end mark in the middle of the features
        build_frame("3", 0, 0, 0, 0, 0);
        frame_q = frame_q[0:9];
        frame_q.push_back(END_MARK);
        send_frame_q();
    endtask

    // longest accepted frame, then one byte too many
    task automatic test_frame_length();
        send_long_frame(MAX_LEN - 2, END_MARK);
        send_long_frame(MAX_LEN - 1, END_MARK);
        send_long_frame(MAX_LEN - 1, "q");
        // state must be clean again after the discard
        send_tree_frame("2", 0, 0, 10, 0, 0);
    endtask

    // mostly well-formed frames with random content, some broken ones and noise
    task automatic test_random_traffic();
        int                kind;
        int                cut;
        int                code_goal;
        logic [BYTE_W-1:0] depth_ch;
        frame_bytes = 0;
        code_goal   = codes_predicted + RAND_CODES;
        while (frame_bytes < RAND_BYTES || codes_predicted < code_goal)
        begin
            // switch between idling and back-to-back stretches
            if ($urandom_range(0, 7) == 0)
            begin
                rx_burst  = ($urandom_range(0, 3) == 0);
                res_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_byte(BYTE_W'($urandom_range(0, 255)));
            kind = $urandom_range(0, 99);
            if (kind < 3)
                send_long_frame($urandom_range(MAX_LEN - 8, MAX_LEN + 6),
                                ($urandom_range(0, 1) != 0) ? END_MARK :
                                BYTE_W'($urandom_range(1, 255)));
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    depth_ch = BYTE_W'("2" + $urandom_range(0, 2));
                else
                    depth_ch = BYTE_W'($urandom_range(0, 255));
                build_frame(depth_ch,
                            ($urandom_range(0, 1) != 0) ? $urandom_range(0, 99) :
                                                          $urandom_range(0, 999),
                            ($urandom_range(0, 1) != 0) ? $urandom_range(0, 99) :
                                                          $urandom_range(0, 999),
                            ($urandom_range(0, 1) != 0) ? $urandom_range(0, 99) :
                                                          $urandom_range(0, 999),
                            ($urandom_range(0, 1) != 0) ? $urandom_range(0, 99) :
                                                          $urandom_range(0, 999),
                            ($urandom_range(0, 1) != 0) ? $urandom_range(0, 99) :
                                                          $urandom_range(0, 999));
                if (kind < 13)
                    frame_q[$urandom_range(1, frame_q.size() - 2)] =
                        BYTE_W'($urandom_range(1, 255));
                else if (kind < 23)
                begin
                    cut     = $urandom_range(0, frame_q.size() - 2);
                    frame_q = frame_q[0:cut];
                    frame_q.push_back(END_MARK);
                end
                else if (kind < 30)
                    frame_q.insert($urandom_range(1, frame_q.size() - 1), NULL_BYTE);
                send_frame_q();
            end
        end
    endtask

    // result sink and checker
    initial
    begin : class_checker
        int          stall;
        class_code_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = res_burst ? 0 : $urandom_range(0, MAX_GAP);
            repeat (stall)
            begin
                res_ch.ready <= 1'b0;
                @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            if (pending_codes.size() == 0)
            begin
                $display("%0t: unexpected class_code transfer, expected none actual %0d",
                         $time, res_ch.class_code);
                err_cnt++;
            end
            else
            begin
                want = pending_codes.pop_front();
                if (res_ch.class_code !== want)
                begin
                    $display("%0t: class_code mismatch, expected %0d actual %0d",
                             $time, want, res_ch.class_code);
                    err_cnt++;
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        rx_burst       = 1'b0;
        res_burst      = 1'b0;
        err_cnt        = 0;
        frame_bytes    = 0;
        codes_predicted = 0;
        clear_frame_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_drops();
        test_tree_paths();
        test_special_frames();
        test_frame_length();
        test_random_traffic();
        rx_ch.valid <= 1'b0;

        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_cnt == 0)
            $display("framed_decimal_tree_classifier_top_tb: clean");
        else
            $display("framed_decimal_tree_classifier_top_tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("framed_decimal_tree_classifier_top_tb: errors");
        $finish;
    end

endmodule
